FILE: hdl/stereo_widener_haas_crossover_assert.svh
// Assertion macros for the stereo widener.
// Included by the top level; expects a clk and rst in the including scope.
`ifndef STEREO_WIDENER_HAAS_CROSSOVER_ASSERT_SVH
`define STEREO_WIDENER_HAAS_CROSSOVER_ASSERT_SVH

// same-cycle implication, idle during reset
`define SWH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define SWH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/swh_pkg.sv
// Shared types and constants for the stereo widener.
// No dependencies; imported by the top level, swh_lane and swh_mix.
package swh_pkg;

  localparam int COEF_W    = 25;
  localparam int DELAY_W   = 22;
  localparam int FRAC_W    = 8;
  localparam int DINT_W    = DELAY_W - FRAC_W;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [COEF_W-1:0] ONE_Q24 = COEF_W'(1) << 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFECT_ENABLE     = 3'd0,
    REG_DELAY_LEFT_SELECT = 3'd1,
    REG_LOWPASS_COEF      = 3'd2,
    REG_DELAY_AMOUNT      = 3'd3,
    REG_WIDTH_GAIN        = 3'd4
  } cfg_reg_t;

  // strobes from the sequencer to each channel lane
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic wr;
    logic rd;
  } lane_ctrl_t;

  // strobes from the sequencer to the merge stage
  typedef struct packed {
    logic cap0;
    logic interp;
    logic side;
    logic fin;
  } mix_ctrl_t;

endpackage

FILE: hdl/stereo_widener_haas_crossover.sv
// Stereo widener top level: config registers, sequencer, ring addressing, output register.
// Depends on swh_pkg, swh_lane, swh_mix and stereo_widener_haas_crossover_assert.svh.
//
//   port group   dir  payload
//   s_*          in   tdata: in_left, in_right (lowest bits first)
//   m_*          out  tdata: out_left, out_right (lowest bits first)
//   cfg_*        in   register index, write data
//
// A processed request passes through every step before the next is accepted: both lanes
// run the lowpass multiply and update side by side, then the one ring read port is used
// twice for the two interpolation taps, then the width multiply and saturation.
// A pass-through request (effect disabled) goes from acceptance straight to the finish step.
// Reset is synchronous; no clearing pass: unwritten ring entries read as zero by
// comparing against the write pointer until it first wraps. A stalled output only
// holds the block in its last step once a second result is ready.
`include "stereo_widener_haas_crossover_assert.svh"

module stereo_widener_haas_crossover import swh_pkg::*; #(
  parameter int RING_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24,
  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // in_left, in_right
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // out_left, out_right
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int RW = ((AW > DINT_W) ? AW : DINT_W) + 1;
  localparam int RED_STEPS = (DINT_W - AW + 1 > 1) ? (DINT_W - AW + 1) : 1;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(RING_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_UPD, ST_WRITE, ST_RD0, ST_RD1,
    ST_INTERP, ST_SIDE, ST_MIXOUT, ST_FINISH
  } state_t;

  state_t state;

  logic                effect_enable;
  logic                delay_left_select;
  logic [COEF_W-1:0]   lowpass_coef;
  logic [DELAY_W-1:0]  delay_amount;
  logic [GAIN_W-1:0]   width_gain;

  logic [AW-1:0]       wp;
  logic                wrapped;
  logic [AW-1:0]       ired;
  logic [AW-1:0]       ipart;
  logic [AW-1:0]       i0;
  logic [AW-1:0]       i1;
  logic                vld_q;
  logic                pass;
  logic [SAMPLE_BITS-1:0] pt_l;
  logic [SAMPLE_BITS-1:0] pt_r;
  logic [SAMPLE_BITS-1:0] out_l;
  logic [SAMPLE_BITS-1:0] out_r;

  logic                accept;
  logic                out_free;
  logic [COEF_W-1:0]   alpha;
  logic [RW-1:0]       rem;
  logic [AW:0]         ip_inc;
  logic [AW:0]         i0_sum;
  logic [AW-1:0]       rd_addr;
  lane_ctrl_t          lctrl;
  mix_ctrl_t           mctrl;

  logic signed [SAMPLE_BITS-1:0] x_v    [2];
  logic signed [SAMPLE_BITS:0]   low_v  [2];
  logic signed [SAMPLE_BITS-1:0] high_v [2];
  logic [SAMPLE_BITS-1:0]        rdat_v [2];
  logic signed [SAMPLE_BITS-1:0] q;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = TDATA_W'({out_r, out_l});
  assign x_v[0]   = s_tdata[SAMPLE_BITS-1:0];
  assign x_v[1]   = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign alpha    = (lowpass_coef > ONE_Q24) ? ONE_Q24 : lowpass_coef;

  // integer delay modulo the ring depth by restoring compare-subtract
  always_comb begin
    rem = RW'(delay_amount[DELAY_W-1:FRAC_W]);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if ({{(32-RW){1'b0}}, rem} >= (32'(RING_DEPTH) << k)) begin
        rem = rem - RW'(32'(RING_DEPTH) << k);
      end
    end
  end

  assign ip_inc = {1'b0, ired} + (AW+1)'(1);
  assign i0_sum = {1'b0, wp} + DEPTH_W - {1'b0, ipart};
  assign rd_addr = (state == ST_RD0) ? i0 : i1;

  always_comb begin
    lctrl      = '0;
    lctrl.load = accept && effect_enable;
    lctrl.mul  = (state == ST_MUL);
    lctrl.upd  = (state == ST_UPD);
    lctrl.wr   = (state == ST_WRITE);
    lctrl.rd   = (state == ST_RD0) || (state == ST_RD1);
    mctrl        = '0;
    mctrl.cap0   = (state == ST_RD1);
    mctrl.interp = (state == ST_INTERP);
    mctrl.side   = (state == ST_SIDE);
    mctrl.fin    = (state == ST_MIXOUT);
  end

  assign q = vld_q ? $signed(delay_left_select ? rdat_v[0] : rdat_v[1]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      effect_enable     <= 1'b1;
      delay_left_select <= 1'b1;
      lowpass_coef      <= COEF_W'(354754);
      delay_amount      <= DELAY_W'(112896);
      width_gain        <= GAIN_W'(16384);
      wp                <= '0;
      wrapped           <= 1'b0;
      m_tvalid          <= 1'b0;
      pass              <= 1'b0;
      vld_q             <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_EFFECT_ENABLE:     effect_enable     <= cfg_wdata[0];
          REG_DELAY_LEFT_SELECT: delay_left_select <= cfg_wdata[0];
          REG_LOWPASS_COEF:      lowpass_coef      <= cfg_wdata[COEF_W-1:0];
          REG_DELAY_AMOUNT:      delay_amount      <= cfg_wdata[DELAY_W-1:0];
          REG_WIDTH_GAIN:        width_gain        <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // the finish step sets valid itself when the output frees up
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            pass  <= !effect_enable;
            pt_l  <= x_v[0];
            pt_r  <= x_v[1];
            state <= effect_enable ? ST_MUL : ST_FINISH;
          end
        end
        ST_MUL: begin
          ired  <= rem[AW-1:0];
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (delay_amount[FRAC_W-1:0] != '0) begin
            ipart <= (ip_inc == DEPTH_W) ? '0 : ip_inc[AW-1:0];
          end else begin
            ipart <= ired;
          end
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          i0    <= (i0_sum >= DEPTH_W) ? AW'(i0_sum - DEPTH_W) : i0_sum[AW-1:0];
          state <= ST_RD0;
        end
        ST_RD0: begin
          i1    <= (i0 == LAST) ? '0 : i0 + AW'(1);
          vld_q <= wrapped || (i0 <= wp);
          state <= ST_RD1;
        end
        ST_RD1: begin
          vld_q <= wrapped || (i1 <= wp);
          state <= ST_INTERP;
        end
        ST_INTERP: begin
          state <= ST_SIDE;
        end
        ST_SIDE: begin
          state <= ST_MIXOUT;
        end
        ST_MIXOUT: begin
          if (wp == LAST) begin
            wp      <= '0;
            wrapped <= 1'b1;
          end else begin
            wp <= wp + AW'(1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_l    <= pass ? pt_l : res_l;
            out_r    <= pass ? pt_r : res_r;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    swh_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .RING_DEPTH (RING_DEPTH)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lctrl),
      .x_in   (x_v[g]),
      .alpha  (alpha),
      .wr_addr(wp),
      .rd_addr(rd_addr),
      .low    (low_v[g]),
      .high   (high_v[g]),
      .rd_data(rdat_v[g])
    );
  end

  swh_mix #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mix (
    .clk       (clk),
    .ctrl      (mctrl),
    .sel_left  (delay_left_select),
    .frac      (delay_amount[FRAC_W-1:0]),
    .width_gain(width_gain),
    .low_l     (low_v[0]),
    .low_r     (low_v[1]),
    .high_l    (high_v[0]),
    .high_r    (high_v[1]),
    .q         (q),
    .res_l     (res_l),
    .res_r     (res_r)
  );

  `SWH_ASSERT_NOW(a_rd_addr_range, (state == ST_RD0) || (state == ST_RD1), rd_addr <= LAST, "ring read address beyond depth")
  `SWH_ASSERT_NOW(a_wrap_at_zero, $rose(wrapped), wp == '0, "wrap flag set away from ring start")
  `SWH_ASSERT_NEXT(a_hold_on_stall, (state == ST_FINISH) && m_tvalid && !m_tready, (state == ST_FINISH) && m_tvalid, "result dropped while output stalled")
  `SWH_ASSERT_NEXT(a_pass_no_state, accept && !effect_enable, (state == ST_FINISH) && $stable(wp), "pass-through request touched ring state")

endmodule

FILE: hdl/swh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/swh_lane.sv
// One channel lane: one-pole lowpass, high band split and the delay ring.
// Depends on swh_pkg and swh_ram.
module swh_lane import swh_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int RING_DEPTH  = 16384,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctrl_t                    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  logic [COEF_W-1:0]             alpha,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [AW-1:0]                 rd_addr,
  output logic signed [SAMPLE_BITS:0]   low,
  output logic signed [SAMPLE_BITS-1:0] high,
  output logic [SAMPLE_BITS-1:0]        rd_data
);

  localparam int LPW = SAMPLE_BITS + 9;
  localparam int DFW = SAMPLE_BITS + 10;
  localparam int PW  = DFW + COEF_W + 1;
  localparam int HW  = SAMPLE_BITS + 2;
  localparam logic signed [PW-1:0]  RND24 = PW'(1) << 23;
  localparam logic signed [LPW-1:0] RND8  = LPW'(128);
  localparam logic signed [HW-1:0]  SMAX  = HW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [HW-1:0]  SMIN  = -SMAX - HW'(1);

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [LPW-1:0]         lp;
  logic signed [PW-1:0]          prod;
  logic signed [DFW-1:0]         diff;
  logic signed [PW-1:0]          corr;
  logic signed [LPW-1:0]         low_full;
  logic signed [HW-1:0]          high_wide;
  logic signed [SAMPLE_BITS-1:0] high_next;

  assign diff     = (DFW'(x) <<< 8) - DFW'(lp);
  assign corr     = (prod + RND24) >>> 24;
  assign low_full = (lp + RND8) >>> 8;
  assign low      = (SAMPLE_BITS+1)'(low_full);

  always_comb begin
    high_wide = HW'(x) - HW'(low);
    if (high_wide > SMAX) begin
      high_next = SAMPLE_BITS'(SMAX);
    end else if (high_wide < SMIN) begin
      high_next = SAMPLE_BITS'(SMIN);
    end else begin
      high_next = SAMPLE_BITS'(high_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0;
    end else if (ctrl.upd) begin
      lp <= lp + LPW'(corr);
    end
    if (ctrl.load) begin
      x <= x_in;
    end
    if (ctrl.mul) begin
      prod <= PW'(diff) * PW'($signed({1'b0, alpha}));
    end
    if (ctrl.wr) begin
      high <= high_next;
    end
  end

  swh_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ctrl.wr),
    .waddr(wr_addr),
    .wdata(high_next),
    .re   (ctrl.rd),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

endmodule

FILE: hdl/swh_mix.sv
// Merge stage: fractional delay interpolation, mid/side width and output saturation.
// Depends on swh_pkg.
module swh_mix import swh_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  mix_ctrl_t                     ctrl,
  input  logic                          sel_left,
  input  logic [FRAC_W-1:0]             frac,
  input  logic [GAIN_W-1:0]             width_gain,
  input  logic signed [SAMPLE_BITS:0]   low_l,
  input  logic signed [SAMPLE_BITS:0]   low_r,
  input  logic signed [SAMPLE_BITS-1:0] high_l,
  input  logic signed [SAMPLE_BITS-1:0] high_r,
  input  logic signed [SAMPLE_BITS-1:0] q,
  output logic signed [SAMPLE_BITS-1:0] res_l,
  output logic signed [SAMPLE_BITS-1:0] res_r
);

  localparam int AW2 = SAMPLE_BITS + 11;
  localparam int SW  = SAMPLE_BITS + GAIN_W + 2;
  localparam int BW  = SAMPLE_BITS + 3;
  localparam int TW  = SAMPLE_BITS + GAIN_W + 4;
  localparam logic signed [AW2-1:0] RND8  = AW2'(128);
  localparam logic signed [TW-1:0]  RND15 = TW'(1) << 14;
  localparam logic signed [TW-1:0]  SMAX  = TW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [TW-1:0]  SMIN  = -SMAX - TW'(1);

  logic signed [SAMPLE_BITS-1:0] s0;
  logic signed [SAMPLE_BITS-1:0] hd;
  logic signed [SW-1:0]          side;
  logic signed [BW-1:0]          base;

  logic [FRAC_W:0]               w0;
  logic [FRAC_W:0]               w1;
  logic signed [AW2-1:0]         acc;
  logic signed [AW2-1:0]         acc_rnd;
  logic signed [SAMPLE_BITS-1:0] hl_eff;
  logic signed [SAMPLE_BITS-1:0] hr_eff;
  logic signed [SAMPLE_BITS:0]   dlt;
  logic signed [TW-1:0]          bs;
  logic signed [TW-1:0]          tp;
  logic signed [TW-1:0]          tm;
  logic signed [TW-1:0]          rp;
  logic signed [TW-1:0]          rm;

  // zero fraction puts the whole weight on the nearer tap
  assign w0 = (frac == '0) ? (FRAC_W+1)'(256) : {1'b0, frac};
  assign w1 = (FRAC_W+1)'(256) - w0;

  assign acc     = AW2'(s0) * AW2'($signed({1'b0, w0})) + AW2'(q) * AW2'($signed({1'b0, w1}));
  assign acc_rnd = (acc + RND8) >>> 8;

  assign hl_eff = sel_left ? hd : high_l;
  assign hr_eff = sel_left ? high_r : hd;
  assign dlt    = (SAMPLE_BITS+1)'(hl_eff) - (SAMPLE_BITS+1)'(hr_eff);

  assign bs = TW'(base) <<< GAIN_FRAC;
  assign tp = bs + TW'(side) + RND15;
  assign tm = bs - TW'(side) + RND15;
  assign rp = tp >>> 15;
  assign rm = tm >>> 15;

  always_ff @(posedge clk) begin
    if (ctrl.cap0) begin
      s0 <= q;
    end
    if (ctrl.interp) begin
      hd <= SAMPLE_BITS'(acc_rnd);
    end
    if (ctrl.side) begin
      side <= SW'(dlt) * SW'($signed({1'b0, width_gain}));
      base <= BW'(low_l) + BW'(low_r) + BW'(hl_eff) + BW'(hr_eff);
    end
    if (ctrl.fin) begin
      res_l <= (rp > SMAX) ? SAMPLE_BITS'(SMAX) :
               (rp < SMIN) ? SAMPLE_BITS'(SMIN) : SAMPLE_BITS'(rp);
      res_r <= (rm > SMAX) ? SAMPLE_BITS'(SMAX) :
               (rm < SMIN) ? SAMPLE_BITS'(SMIN) : SAMPLE_BITS'(rm);
    end
  end

endmodule
